// ----- hdl/psrl_pkg.sv -----
// Package for the per-source rate limiter: default sizes, register indexes,
// window lengths and the saturating counter helper.
// No dependencies.
`timescale 1ns / 1ps

package psrl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int TIME_BITS_DEF     = 32;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_MINUTE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_HOUR   = CFG_INDEX_W'(1);

    localparam logic [COUNT_W-1:0] LIMIT_MINUTE_RST = COUNT_W'(10);
    localparam logic [COUNT_W-1:0] LIMIT_HOUR_RST   = COUNT_W'(100);
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

    localparam int MINUTE_SECONDS = 60;
    localparam int HOUR_SECONDS   = 3600;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

endpackage

// ----- hdl/per_source_rate_limiter_core.sv -----
// Fixed-window rate limiter keyed by source address: top level with the
// sequencer, the shared add/subtract unit and the source table RAM.
// Depends on psrl_pkg and psrl_ram.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. The block then scans
// its source table linearly, one entry per cycle through the single read port
// of the table RAM, and takes no new item until its verdict is out; a blocked
// request also passes through the retry states before its result. The
// result shows on the result ports for one cycle with o_valid high, in the
// cycle that busy falls; the receiver cannot stall it, so it must take every
// result as it comes. A new source is stored and passes; once the table is
// full, new sources pass unstored with o_table_full set. The limit registers
// are written only while the block is not busy, which o_cfg_ready shows.
module per_source_rate_limiter_core #(
    parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF,
    parameter int TIME_BITS     = psrl_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [psrl_pkg::ADDR_W-1:0]      i_source_address,
    input  logic [31:0]                      i_current_time,
    output logic                             o_valid,
    output logic                             o_allowed,
    output logic [31:0]                      o_retry_at,
    output logic                             o_table_full,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [psrl_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [psrl_pkg::COUNT_W-1:0]     i_cfg_data
);

    import psrl_pkg::*;

    localparam int TB     = TIME_BITS;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W = ADDR_W + TB + 2 * COUNT_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [TB-1:0]    MINUTE_T   = TB'(MINUTE_SECONDS);
    localparam logic [TB-1:0]    HOUR_T     = TB'(HOUR_SECONDS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_NEW    = 3'd2;
    localparam logic [2:0] ST_GAP    = 3'd3;
    localparam logic [2:0] ST_COUNT  = 3'd4;
    localparam logic [2:0] ST_RETRY1 = 3'd5;
    localparam logic [2:0] ST_RETRY2 = 3'd6;

    // Control registers.
    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_o_valid, n_o_valid;
    logic [COUNT_W-1:0] r_limit_min, r_limit_hour;

    // Payload registers.
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [TB-1:0]      r_time, n_time;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic [TB-1:0]      r_last, n_last;
    logic [COUNT_W-1:0] r_min, n_min;
    logic [COUNT_W-1:0] r_hour, n_hour;
    logic [TB-1:0]      r_gap, n_gap;
    logic [TB-1:0]      r_acc, n_acc;
    logic               r_blk_min, n_blk_min;
    logic               r_blk_hour, n_blk_hour;
    logic               r_o_allowed, n_o_allowed;
    logic [TB-1:0]      r_o_retry, n_o_retry;
    logic               r_o_full, n_o_full;

    // Table RAM port signals.
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [WORD_W-1:0]  w_wr_data;
    logic               w_rd_en;
    logic [WORD_W-1:0]  w_rd_data;
    logic [ADDR_W-1:0]  w_rd_src;
    logic               w_hit;

    // Shared add/subtract unit.
    logic [TB-1:0]      w_op_a, w_op_b, w_sum;
    logic               w_op_sub;

    logic [TB+31:0]     w_time_ext;
    logic [TB+31:0]     w_retry_ext;
    logic [COUNT_W-1:0] w_new_min, w_new_hour;

    assign w_time_ext  = {{TB{1'b0}}, i_current_time};
    assign w_retry_ext = {32'd0, r_o_retry};

    assign w_rd_src = w_rd_data[WORD_W-1 -: ADDR_W];
    assign w_hit    = r_pend && (w_rd_src == r_addr);
    assign w_rd_en  = (r_state == ST_SCAN) && (r_idx < r_fill);

    assign w_sum = w_op_sub ? (w_op_a - w_op_b) : (w_op_a + w_op_b);

    // A gap of a full window clears the count before the increment.
    assign w_new_min  = sat_inc((r_gap >= MINUTE_T) ? '0 : r_min);
    assign w_new_hour = sat_inc((r_gap >= HOUR_T) ? '0 : r_hour);

    psrl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_o_valid   = 1'b0;
        n_addr      = r_addr;
        n_time      = r_time;
        n_cmp_idx   = r_cmp_idx;
        n_hit_idx   = r_hit_idx;
        n_last      = r_last;
        n_min       = r_min;
        n_hour      = r_hour;
        n_gap       = r_gap;
        n_acc       = r_acc;
        n_blk_min   = r_blk_min;
        n_blk_hour  = r_blk_hour;
        n_o_allowed = r_o_allowed;
        n_o_retry   = r_o_retry;
        n_o_full    = r_o_full;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_hit_idx;
        w_wr_data   = {r_addr, r_time, w_new_min, w_new_hour};
        w_op_a      = r_time;
        w_op_b      = r_gap;
        w_op_sub    = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_addr  = i_source_address;
                    n_time  = w_time_ext[TB-1:0];
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Reads are issued one per cycle; the compare runs one entry behind.
                if (w_rd_en) begin
                    n_idx     = r_idx + CNT_W'(1);
                    n_pend    = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end
                if (w_hit) begin
                    n_hit_idx = r_cmp_idx;
                    n_last    = w_rd_data[2*COUNT_W +: TB];
                    n_min     = w_rd_data[COUNT_W +: COUNT_W];
                    n_hour    = w_rd_data[COUNT_W-1:0];
                    n_state   = ST_GAP;
                end else if (r_idx == r_fill) begin
                    n_state = ST_NEW;
                end
            end
            ST_NEW: begin
                n_o_valid   = 1'b1;
                n_o_allowed = 1'b1;
                n_o_retry   = '0;
                if (r_fill < FULL_COUNT) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_fill[IDX_W-1:0];
                    w_wr_data = {r_addr, r_time, COUNT_W'(1), COUNT_W'(1)};
                    n_fill    = r_fill + CNT_W'(1);
                    n_o_full  = 1'b0;
                end else begin
                    n_o_full = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_GAP: begin
                w_op_a   = r_time;
                w_op_b   = r_last;
                w_op_sub = 1'b1;
                n_gap    = w_sum;
                n_state  = ST_COUNT;
            end
            ST_COUNT: begin
                w_wr_en    = 1'b1;
                n_blk_min  = (w_new_min >= r_limit_min);
                n_blk_hour = (w_new_hour >= r_limit_hour);
                n_state    = ST_RETRY1;
            end
            ST_RETRY1: begin
                if (!r_blk_min && !r_blk_hour) begin
                    n_o_valid   = 1'b1;
                    n_o_allowed = 1'b1;
                    n_o_retry   = '0;
                    n_o_full    = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    w_op_a   = r_time;
                    w_op_b   = r_gap;
                    w_op_sub = 1'b1;
                    n_acc    = w_sum;
                    n_state  = ST_RETRY2;
                end
            end
            ST_RETRY2: begin
                // The minute window takes priority over the hour window.
                w_op_a      = r_acc;
                w_op_b      = r_blk_min ? MINUTE_T : HOUR_T;
                w_op_sub    = 1'b0;
                n_o_valid   = 1'b1;
                n_o_allowed = 1'b0;
                n_o_retry   = w_sum;
                n_o_full    = 1'b0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill       <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_o_valid    <= 1'b0;
            r_limit_min  <= LIMIT_MINUTE_RST;
            r_limit_hour <= LIMIT_HOUR_RST;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_LIMIT_MINUTE) begin
                    r_limit_min <= i_cfg_data;
                end else if (i_cfg_index == REG_LIMIT_HOUR) begin
                    r_limit_hour <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_time      <= n_time;
        r_cmp_idx   <= n_cmp_idx;
        r_hit_idx   <= n_hit_idx;
        r_last      <= n_last;
        r_min       <= n_min;
        r_hour      <= n_hour;
        r_gap       <= n_gap;
        r_acc       <= n_acc;
        r_blk_min   <= n_blk_min;
        r_blk_hour  <= n_blk_hour;
        r_o_allowed <= n_o_allowed;
        r_o_retry   <= n_o_retry;
        r_o_full    <= n_o_full;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_allowed    = r_o_allowed;
    assign o_retry_at   = w_retry_ext[31:0];
    assign o_table_full = r_o_full;
    assign o_cfg_ready  = !busy;

endmodule

// ----- hdl/psrl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module psrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- verif/rate_verdict_checker.sv -----
// Checker for the per-source rate limiter: watches the request, result and
// register channels, predicts each verdict and compares it with the block.
// Depends on psrl_pkg.
`timescale 1ns / 1ps

module rate_verdict_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [psrl_pkg::ADDR_W-1:0]      i_req_address,
    input  logic [31:0]                      i_req_stamp,
    input  logic                             i_res_valid,
    input  logic                             i_res_allowed,
    input  logic [31:0]                      i_res_retry_at,
    input  logic                             i_res_table_full,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [psrl_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [psrl_pkg::COUNT_W-1:0]     i_cfg_data,
    output int                               o_outstanding,
    output int                               o_err_count
);

    import psrl_pkg::*;

    localparam int SLOTS = TABLE_ENTRIES_DEF;

    typedef struct packed {
        logic        allowed;
        logic [31:0] retry_at;
        logic        table_full;
    } t_verdict;

    logic [ADDR_W-1:0]  src_addr [SLOTS];
    logic [31:0]        src_last [SLOTS];
    logic [COUNT_W-1:0] src_minute [SLOTS];
    logic [COUNT_W-1:0] src_hour [SLOTS];
    int                 sources_held;
    logic [COUNT_W-1:0] cap_minute;
    logic [COUNT_W-1:0] cap_hour;
    t_verdict           due_verdicts [$];

    function automatic t_verdict judge_request(input logic [ADDR_W-1:0] addr,
                                               input logic [31:0] stamp);
        t_verdict    v;
        int          slot;
        logic [31:0] gap;
        v = '{allowed: 1'b1, retry_at: 32'd0, table_full: 1'b0};
        slot = -1;
        // The first match in scan order wins.
        for (int k = 0; k < sources_held; k++)
            if (slot < 0 && src_addr[k] == addr)
                slot = k;
        if (slot < 0) begin
            if (sources_held < SLOTS) begin
                src_addr[sources_held] = addr;
                src_last[sources_held] = stamp;
                src_minute[sources_held] = COUNT_W'(1);
                src_hour[sources_held] = COUNT_W'(1);
                sources_held++;
            end else begin
                v.table_full = 1'b1;
            end
        end else begin
            // The gap is an unsigned difference, so a step back in time is a huge gap.
            gap = stamp - src_last[slot];
            src_last[slot] = stamp;
            if (gap >= 32'(MINUTE_SECONDS))
                src_minute[slot] = '0;
            if (gap >= 32'(HOUR_SECONDS))
                src_hour[slot] = '0;
            if (src_minute[slot] != '1)
                src_minute[slot] = src_minute[slot] + COUNT_W'(1);
            if (src_hour[slot] != '1)
                src_hour[slot] = src_hour[slot] + COUNT_W'(1);
            if (src_minute[slot] >= cap_minute) begin
                v.allowed = 1'b0;
                v.retry_at = stamp + 32'(MINUTE_SECONDS) - gap;
            end else if (src_hour[slot] >= cap_hour) begin
                v.allowed = 1'b0;
                v.retry_at = stamp + 32'(HOUR_SECONDS) - gap;
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            sources_held = 0;
            cap_minute = LIMIT_MINUTE_RST;
            cap_hour = LIMIT_HOUR_RST;
            due_verdicts.delete();
            o_outstanding = 0;
            o_err_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LIMIT_MINUTE: cap_minute = i_cfg_data;
                    REG_LIMIT_HOUR:   cap_hour = i_cfg_data;
                    default: ;
                endcase
            end
            // A result may leave in the same cycle that the next item is taken,
            // so the result is matched first.
            if (i_res_valid) begin
                got = '{allowed: i_res_allowed, retry_at: i_res_retry_at,
                        table_full: i_res_table_full};
                if (due_verdicts.size() == 0) begin
                    if (o_err_count < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    o_err_count++;
                end else begin
                    want = due_verdicts.pop_front();
                    if (got !== want) begin
                        if (o_err_count < 10)
                            $display({"%0t: verdict mismatch (expected/actual): ",
                                      "allowed %0d/%0d retry_at %h/%h table_full %0d/%0d"},
                                     $realtime, want.allowed, got.allowed, want.retry_at,
                                     got.retry_at, want.table_full, got.table_full);
                        o_err_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                due_verdicts.push_back(judge_request(i_req_address, i_req_stamp));
            o_outstanding = due_verdicts.size();
        end
    end

endmodule

// ----- verif/per_source_rate_limiter_core_test.sv -----
// Testbench top for the per-source rate limiter: drives requests and limit
// writes with random pacing and gives the verdict.
// Depends on psrl_pkg, per_source_rate_limiter_core and rate_verdict_checker.
`timescale 1ns / 1ps

module per_source_rate_limiter_core_test;
    import psrl_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = TABLE_ENTRIES_DEF + 16;
    localparam int POOL = 72;
    localparam int PHASES = 7;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ADDR_W-1:0]      i_source_address = '0;
    logic [31:0]            i_current_time = '0;
    logic                   o_valid;
    logic                   o_allowed;
    logic [31:0]            o_retry_at;
    logic                   o_table_full;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [COUNT_W-1:0]     i_cfg_data = '0;

    int          outstanding;
    int          err_count;
    int unsigned cycles = 0;
    logic [31:0] pool [POOL];
    logic [31:0] now_s = '0;

    always #5 i_clk = ~i_clk;

    per_source_rate_limiter_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_source_address (i_source_address),
        .i_current_time   (i_current_time),
        .o_valid          (o_valid),
        .o_allowed        (o_allowed),
        .o_retry_at       (o_retry_at),
        .o_table_full     (o_table_full),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    rate_verdict_checker u_verdicts (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_req_address    (i_source_address),
        .i_req_stamp      (i_current_time),
        .i_res_valid      (o_valid),
        .i_res_allowed    (o_allowed),
        .i_res_retry_at   (o_retry_at),
        .i_res_table_full (o_table_full),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_outstanding    (outstanding),
        .o_err_count      (err_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[per_source_rate_limiter_core] ERROR");
            $finish;
        end
    end

    // Start stays high across items when no idle cycles are drawn, so the
    // next item may wait on busy for any part of the scan.
    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [31:0] stamp,
                                input int idle);
        @(negedge i_clk);
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        start <= 1'b1;
        i_source_address <= addr;
        i_current_time <= stamp;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small steps so that windows fill up, with steps that land on
    // both window edges, steps back in time and wild jumps.
    function automatic logic [31:0] next_stamp(input logic [31:0] stamp);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return stamp + $urandom_range(0, 5);
        if (pick < 85)
            return stamp + $urandom_range(55, 70);
        if (pick < 93)
            return stamp + $urandom_range(3590, 3700);
        if (pick < 96)
            return stamp - $urandom_range(1, 100);
        if (pick < 98)
            return 32'hFFFF_FFC0 + $urandom_range(0, 63);
        return $urandom;
    endfunction

    // Bursts from one source, now and then interleaved with other sources.
    task automatic run_bursts(input int count);
        int          sent;
        int          len;
        logic [31:0] who;
        logic [31:0] addr;
        bit          calm;
        sent = 0;
        while (sent < count) begin
            who = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL - 1)] : $urandom;
            len = $urandom_range(1, 14);
            calm = ($urandom_range(0, 9) < 3);
            repeat (len) begin
                addr = ($urandom_range(0, 9) == 0) ? pool[$urandom_range(0, POOL - 1)] : who;
                now_s = next_stamp(now_s);
                send_request(addr, now_s, calm ? 0 : $urandom_range(0, 17));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int cap_minute [PHASES];
        int cap_hour [PHASES];
        int quota [PHASES];
        cap_minute = '{10, 1, 65535, 65535, 6, 0, 0};
        cap_hour   = '{100, 1, 65535, 3, 20, 0, 0};
        quota      = '{350, 150, 200, 300, 400, 100, 450};
        cap_minute[PHASES - 1] = $urandom_range(1, 16);
        cap_hour[PHASES - 1] = $urandom_range(1, 64);
        for (int k = 0; k < POOL; k++)
            pool[k] = $urandom;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: fill a minute window, then cross both window edges.
        send_request(32'h0000_0000, 32'd0, 0);
        send_request(32'hFFFF_FFFF, 32'd5, 0);
        for (int k = 0; k < 11; k++)
            send_request(32'h0000_0000, 32'd10 + k, 0);
        send_request(32'h0000_0000, 32'd79, 0);
        send_request(32'h0000_0000, 32'd139, 0);
        send_request(32'h0000_0000, 32'd3739, 0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(32'hFFFF_FFFF, 32'd3, 0);

        // A zero minute limit blocks known sources but never a new one.
        settle();
        write_limit(REG_LIMIT_MINUTE, COUNT_W'(0));
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFF0, 3);
        send_request(32'h1234_5678, 32'hFFFF_FFF1, 0);

        // Hour block with a retry time that wraps; an unmapped index is ignored.
        settle();
        write_limit(REG_LIMIT_MINUTE, '1);
        write_limit(REG_LIMIT_HOUR, COUNT_W'(2));
        write_limit(REG_SPARE, COUNT_W'(1));
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(32'h1234_5678, 32'hFFFF_FFFF, 5);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_limit(REG_LIMIT_MINUTE, COUNT_W'(cap_minute[p]));
            write_limit(REG_LIMIT_HOUR, COUNT_W'(cap_hour[p]));
            now_s = (p % 2 == 1) ? 32'hFFFF_FF00 + $urandom_range(0, 200) : $urandom;
            run_bursts(quota[p]);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("[per_source_rate_limiter_core] OK");
        else
            $display("[per_source_rate_limiter_core] ERROR");
        $finish;
    end

endmodule
